[rtl/ebc_pkg.sv]
// ----------------------------------------------------------------------------
// ebc_pkg
// Shared types, constants and functions of the 8-bit processor core.
// ----------------------------------------------------------------------------
package ebc_pkg;

  localparam int AddrBitsDefault = 16;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_EXEC  = 2'd2;

  localparam logic [15:0] INT_VECTOR = 16'h0008;

  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_N = 2;

  // register file indexes
  localparam logic [2:0] REG_F = 3'd0;
  localparam logic [2:0] REG_A = 3'd1;

  // alu operations
  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_SUB = 3'd2;
  localparam logic [2:0] ALU_AND = 3'd4;
  localparam logic [2:0] ALU_OR  = 3'd5;
  localparam logic [2:0] ALU_XOR = 3'd6;
  localparam logic [2:0] ALU_CP  = 3'd7;

  typedef struct packed {
    logic [7:0] res;
    logic [7:0] flags;
    logic       wr_flags;
  } alu_res_t;

  // true for opcodes without meaning
  function automatic logic op_invalid(input logic [7:0] op);
    op_invalid = (op == 8'h06) || (op == 8'h07) || (op >= 8'h0C && op <= 8'h17) ||
                 (op == 8'h3F) || (op == 8'h67) || (op == 8'h6F);
  endfunction

  function automatic logic cond_met(input logic [2:0] c, input logic [7:0] f);
    logic b;
    b = f[c[1:0]];
    if (c[1:0] == 2'd3) cond_met = 1'b1;
    else cond_met = c[2] ? !b : b;
  endfunction

  function automatic alu_res_t alu(input logic [2:0] op, input logic [7:0] s,
                                   input logic [7:0] v, input logic [7:0] f);
    alu_res_t r;
    logic [8:0] w;
    logic       c;
    r = '0;
    c = op[0] && f[FLAG_C] && (op != ALU_CP);
    w = '0;
    case (op)
      ALU_AND: r.res = s & v;
      ALU_OR:  r.res = s | v;
      ALU_XOR: r.res = s ^ v;
      default: begin
        if (op[1]) w = {1'b0, s} - {1'b0, v} - {8'd0, c};
        else w = {1'b0, s} + {1'b0, v} + {8'd0, c};
        r.wr_flags = 1'b1;
        r.flags = {5'd0, w[7], (w[7:0] == 8'd0), w[8]};
        r.res = (op == ALU_CP) ? s : w[7:0];
      end
    endcase
    alu = r;
  endfunction

endpackage

[rtl/ebc_mem.sv]
// ----------------------------------------------------------------------------
// ebc_mem
// Byte-wide main memory, one write or one read a cycle, registered read.
// ----------------------------------------------------------------------------
module ebc_mem import ebc_pkg::*; #(
  parameter int ADDR_BITS = AddrBitsDefault
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [7:0]           wdata,
  output logic [7:0]           rdata
);

  logic [7:0] mem [2**ADDR_BITS];

  // single port array
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

[rtl/eight_bit_cpu_core_top.sv]
// ----------------------------------------------------------------------------
// eight_bit_cpu_core_top
// 8-bit processor core: byte loads, start, and single instruction steps.
// ----------------------------------------------------------------------------
//  channel | ports                                              | direction
//  input   | in_valid in_stall in_kind in_address in_data ...   | in word
//  output  | out_valid out_stall out_running out_fault out_pc.. | out word
//
// One word at a time through a sequencer around the single memory port.
// A load, start or idle step passes through IDLE and DONE. An instruction passes
// FETCH, WAIT and EXEC per fetched byte, PUSH per pushed byte, POP for a pop,
// and HL then EXEC for the byte at HL; a call taken on interrupt entry is longest.
// Synchronous active-low reset, no clearing pass.
// The next input word is taken once the result has left, or leaves in that cycle.
module eight_bit_cpu_core_top import ebc_pkg::*; #(
  parameter int ADDR_BITS = AddrBitsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_data,
  input  logic [7:0]  in_irq_lines,
  input  logic [7:0]  in_io_read_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_running,
  output logic        out_fault,
  output logic [15:0] out_pc,
  output logic [7:0]  out_acc,
  output logic [2:0]  out_flags,
  output logic        out_io_write,
  output logic [7:0]  out_io_port,
  output logic [7:0]  out_io_data,
  output logic        out_io_read
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_FETCH = 8'b00000010,
    S_WAIT  = 8'b00000100,
    S_EXEC  = 8'b00001000,
    S_PUSH  = 8'b00010000,
    S_POP   = 8'b00100000,
    S_HL    = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  // what to do when a push or pop finishes
  typedef enum logic [3:0] {
    K_INT   = 4'b0001,
    K_PAIR  = 4'b0010,
    K_RET   = 4'b0100,
    K_NONE  = 4'b1000
  } cont_t;

  state_t      state_r, state_nxt;
  cont_t       cont_r, cont_nxt;
  logic [15:0] pc_r, pc_nxt, sp_r, sp_nxt;
  logic [7:0]  rf_r [8];
  logic [7:0]  rf_nxt [8];
  logic        ie_r, ie_nxt, run_r, run_nxt, fault_r, fault_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [7:0]  op_r, op_nxt;
  logic [1:0]  cnt_r, cnt_nxt;      // bytes fetched after the opcode / stack bytes
  logic [15:0] tmp_r, tmp_nxt;      // operand or stack word
  logic        hl_r, hl_nxt;        // byte at HL has been read into tmp
  logic        opv_r, opv_nxt;      // opcode latched
  logic        ov_r, ov_nxt;
  logic        iow_r, iow_nxt, ior_r, ior_nxt;
  logic [7:0]  iop_r, iop_nxt, iod_r, iod_nxt;
  logic [15:0] a_r, a_nxt;
  logic [7:0]  irq_r, irq_nxt, iord_r, iord_nxt;

  logic        m_we;
  logic [15:0] m_addr;
  logic [7:0]  m_wd, m_rd;

  ebc_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (
    .clk(clk), .we(m_we), .addr(m_addr[ADDR_BITS-1:0]), .wdata(m_wd), .rdata(m_rd)
  );

  assign in_stall     = (state_r != S_IDLE) || (ov_r && out_stall);
  assign out_valid    = ov_r;
  assign out_running  = run_r;
  assign out_fault    = fault_r;
  assign out_pc       = pc_r;
  assign out_acc      = rf_r[REG_A];
  assign out_flags    = rf_r[REG_F][2:0];
  assign out_io_write = iow_r;
  assign out_io_port  = iop_r;
  assign out_io_data  = iod_r;
  assign out_io_read  = ior_r;

  // sequencer
  always_comb begin
    logic [15:0] hl, pv, nv;
    logic [7:0]  op, src, v8;
    logic [2:0]  ri;
    logic        need_hl;
    alu_res_t    ar;
    state_nxt = state_r; cont_nxt = cont_r;
    pc_nxt = pc_r; sp_nxt = sp_r; rf_nxt = rf_r;
    ie_nxt = ie_r; run_nxt = run_r; fault_nxt = fault_r; pend_nxt = pend_r;
    op_nxt = op_r; cnt_nxt = cnt_r; tmp_nxt = tmp_r; hl_nxt = hl_r; opv_nxt = opv_r;
    ov_nxt = ov_r && out_stall;
    iow_nxt = iow_r; ior_nxt = ior_r; iop_nxt = iop_r; iod_nxt = iod_r;
    a_nxt = a_r; irq_nxt = irq_r; iord_nxt = iord_r;
    m_we = 1'b0; m_addr = pc_r; m_wd = 8'd0;
    hl = {rf_r[7], rf_r[6]};
    op = op_r;
    pv = {rf_r[{op[1:0], 1'b1}], rf_r[{op[1:0], 1'b0}]};
    nv = '0; src = 8'd0; v8 = 8'd0; ri = 3'd0; need_hl = 1'b0; ar = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          a_nxt = in_address;
          irq_nxt = in_irq_lines; iord_nxt = in_io_read_data;
          iow_nxt = 1'b0; ior_nxt = 1'b0; iop_nxt = 8'd0; iod_nxt = 8'd0;
          state_nxt = S_DONE;
          if (in_kind == KIND_LOAD) begin
            m_we = 1'b1; m_addr = in_address; m_wd = in_data;
          end else if (in_kind == KIND_START) begin
            run_nxt = 1'b1; fault_nxt = 1'b0;
          end else if (in_kind == KIND_EXEC && run_r) begin
            opv_nxt = 1'b0; cnt_nxt = 2'd0; hl_nxt = 1'b0;
            if (ie_r && pend_r != 8'd0) begin
              tmp_nxt = pc_r; ie_nxt = 1'b0; cont_nxt = K_INT; state_nxt = S_PUSH;
            end else begin
              state_nxt = S_FETCH;
            end
          end
        end
      end
      S_FETCH: begin
        // read byte at pc
        m_addr = pc_r; pc_nxt = pc_r + 16'd1; state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!opv_r) begin
          op_nxt = m_rd; opv_nxt = 1'b1;
        end else begin
          if (cnt_r == 2'd0) tmp_nxt[7:0] = m_rd;
          else tmp_nxt[15:8] = m_rd;
          cnt_nxt = cnt_r + 2'd1;
        end
        state_nxt = S_EXEC;
      end
      S_HL: begin
        tmp_nxt[7:0] = m_rd; hl_nxt = 1'b1; state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        pend_nxt = pend_r | irq_r;
        if (op_invalid(op)) begin
          fault_nxt = 1'b1; run_nxt = 1'b0; pend_nxt = pend_r;
        end else if (op == 8'h01) run_nxt = 1'b0;
        else if (op == 8'h02) ie_nxt = 1'b1;
        else if (op == 8'h03) ie_nxt = 1'b0;
        else if (op == 8'h04) rf_nxt[REG_A] = pend_r;
        else if (op == 8'h05) pend_nxt = irq_r;
        else if ((op >= 8'h08 && op <= 8'h0B) || (op >= 8'h60 && op <= 8'h6F)) begin
          if (cnt_r != 2'd2) begin
            state_nxt = S_FETCH; pend_nxt = pend_r;
          end else if (op < 8'h60) begin
            rf_nxt[{op[1:0], 1'b0}] = tmp_r[7:0];
            rf_nxt[{op[1:0], 1'b1}] = tmp_r[15:8];
          end else if (cond_met(op[2:0], rf_r[REG_F])) begin
            if (op[3]) begin
              pend_nxt = pend_r; a_nxt = tmp_r; tmp_nxt = pc_r; cnt_nxt = 2'd0;
              cont_nxt = K_NONE; state_nxt = S_PUSH;
            end else pc_nxt = tmp_r;
          end
        end else if (op >= 8'h18 && op <= 8'h27) begin
          if (cnt_r == 2'd0) begin
            state_nxt = S_FETCH; pend_nxt = pend_r;
          end else if (op < 8'h20) begin
            if (op[2:0] == 3'd0) begin
              m_we = 1'b1; m_addr = hl; m_wd = tmp_r[7:0];
            end else rf_nxt[op[2:0]] = tmp_r[7:0];
          end else begin
            ar = alu(op[2:0], rf_r[REG_A], tmp_r[7:0], rf_r[REG_F]);
            rf_nxt[REG_A] = ar.res;
            if (ar.wr_flags) rf_nxt[REG_F] = ar.flags;
          end
        end else if (op >= 8'h28 && op <= 8'h2F) begin
          nv = op[2] ? pv + 16'd1 : pv - 16'd1;
          rf_nxt[{op[1:0], 1'b0}] = nv[7:0];
          rf_nxt[{op[1:0], 1'b1}] = nv[15:8];
        end else if (op >= 8'h30 && op <= 8'h3E) begin
          pend_nxt = pend_r; cnt_nxt = 2'd0;
          if (op < 8'h34) begin
            tmp_nxt = pv; cont_nxt = K_NONE; state_nxt = S_PUSH;
          end else if (op < 8'h38) begin
            cont_nxt = K_PAIR; state_nxt = S_POP;
          end else if (cond_met(op[2:0], rf_r[REG_F])) begin
            cont_nxt = K_RET; state_nxt = S_POP;
          end else pend_nxt = pend_r | irq_r;
        end else if (op >= 8'h40 && op <= 8'h4F) begin
          rf_nxt[{op[3:2], 1'b0}] = pv[7:0];
          rf_nxt[{op[3:2], 1'b1}] = pv[15:8];
        end else if (op >= 8'h50) begin
          // byte-operand groups: in/out, inc/dec, alu, move
          ri = op[2:0];
          need_hl = (ri == 3'd0) && !hl_r;
          src = (ri == 3'd0) ? tmp_r[7:0] : rf_r[ri];
          if (need_hl) begin
            m_addr = hl; state_nxt = S_HL; pend_nxt = pend_r;
          end else if (op <= 8'h5F) begin
            iop_nxt = src;
            if (op[3]) begin
              rf_nxt[REG_A] = iord_r; ior_nxt = 1'b1;
            end else begin
              iod_nxt = rf_r[REG_A]; iow_nxt = 1'b1;
            end
          end else if (op <= 8'h7F) begin
            ar = alu(op[3] ? ALU_ADD : ALU_SUB, src, 8'd1, rf_r[REG_F]);
            rf_nxt[REG_F] = ar.flags;
            if (ri == 3'd0) begin
              m_we = 1'b1; m_addr = hl; m_wd = ar.res;
            end else rf_nxt[ri] = ar.res;
          end else if (op <= 8'hBF) begin
            ar = alu(op[5:3], rf_r[REG_A], src, rf_r[REG_F]);
            rf_nxt[REG_A] = ar.res;
            if (ar.wr_flags) rf_nxt[REG_F] = ar.flags;
          end else begin
            v8 = src;
            if (op[5:3] == 3'd0) begin
              m_we = 1'b1; m_addr = hl; m_wd = v8;
            end else rf_nxt[op[5:3]] = v8;
          end
        end
      end
      S_PUSH: begin
        // low byte first at the higher address
        m_we = 1'b1;
        m_addr = sp_r - 16'd1;
        m_wd = (cnt_r == 2'd0) ? tmp_r[7:0] : tmp_r[15:8];
        sp_nxt = sp_r - 16'd1;
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd1) begin
          cnt_nxt = 2'd0;
          case (cont_r)
            K_INT: begin
              pc_nxt = INT_VECTOR; state_nxt = S_FETCH;
            end
            K_NONE: begin
              if (op_r >= 8'h60 && op_r <= 8'h6F) pc_nxt = a_r;
              pend_nxt = pend_r | irq_r; state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_POP: begin
        m_addr = sp_r;
        if (cnt_r != 2'd0) begin
          if (cnt_r == 2'd1) tmp_nxt[15:8] = m_rd;
          else tmp_nxt[7:0] = m_rd;
        end
        if (cnt_r != 2'd2) sp_nxt = sp_r + 16'd1;
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd2) begin
          state_nxt = S_DONE; pend_nxt = pend_r | irq_r;
          if (cont_r == K_RET) pc_nxt = {tmp_r[15:8], m_rd};
          else begin
            rf_nxt[{op_r[1:0], 1'b0}] = m_rd;
            rf_nxt[{op_r[1:0], 1'b1}] = tmp_r[15:8];
          end
        end
      end
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end else ov_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cont_r <= K_NONE;
      pc_r <= '0; sp_r <= '0; ie_r <= 1'b0; run_r <= 1'b0; fault_r <= 1'b0;
      pend_r <= '0; ov_r <= 1'b0; opv_r <= 1'b0; hl_r <= 1'b0; cnt_r <= '0;
      for (int i = 0; i < 8; i++) rf_r[i] <= 8'd0;
    end else begin
      state_r <= state_nxt; cont_r <= cont_nxt;
      pc_r <= pc_nxt; sp_r <= sp_nxt; ie_r <= ie_nxt; run_r <= run_nxt;
      fault_r <= fault_nxt; pend_r <= pend_nxt; ov_r <= ov_nxt;
      opv_r <= opv_nxt; hl_r <= hl_nxt; cnt_r <= cnt_nxt;
      rf_r <= rf_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r <= op_nxt; tmp_r <= tmp_nxt;
    iow_r <= iow_nxt; ior_r <= ior_nxt; iop_r <= iop_nxt; iod_r <= iod_nxt;
    a_r <= a_nxt; irq_r <= irq_nxt; iord_r <= iord_nxt;
  end

endmodule

[dv/tb_eight_bit_cpu_core_top.sv]
// ----------------------------------------------------------------------------
// tb_eight_bit_cpu_core_top
// Self-checking bench for the 8-bit processor core. A directed table of
// loads, starts and steps comes first, then random programs. Code bytes
// are written lazily just before a step would read them. Each result word
// is compared with a typed row's expected word or the bench's own model.
// ----------------------------------------------------------------------------
module tb_eight_bit_cpu_core_top;
  import ebc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_WORDS = 1450;

  // opcodes and opcode group bases
  localparam logic [7:0] OP_HALT     = 8'h01;
  localparam logic [7:0] OP_EI       = 8'h02;
  localparam logic [7:0] OP_DI       = 8'h03;
  localparam logic [7:0] OP_GETPEND  = 8'h04;
  localparam logic [7:0] OP_CLRPEND  = 8'h05;
  localparam logic [7:0] OP_LD16     = 8'h08;
  localparam logic [7:0] OP_LD8      = 8'h18;
  localparam logic [7:0] OP_ALUI     = 8'h20;
  localparam logic [7:0] OP_INCDEC16 = 8'h28;
  localparam logic [7:0] OP_STACK    = 8'h30;
  localparam logic [7:0] OP_RET      = 8'h38;
  localparam logic [7:0] OP_MOV16    = 8'h40;
  localparam logic [7:0] OP_IO       = 8'h50;
  localparam logic [7:0] OP_JP       = 8'h60;
  localparam logic [7:0] OP_INCDEC8  = 8'h70;
  localparam logic [7:0] OP_ALUR     = 8'h80;
  localparam logic [7:0] OP_MOV8     = 8'hC0;
  localparam logic [7:0] OP_BAD_A    = 8'h0F;

  typedef struct packed {
    logic        running;
    logic        fault;
    logic [15:0] pc;
    logic [7:0]  acc;
    logic [2:0]  flags;
    logic        io_write;
    logic [7:0]  io_port;
    logic [7:0]  io_data;
    logic        io_read;
  } res_t;

  typedef struct packed {
    logic [7:0][7:0] rf;
    logic [15:0]     pc;
    logic [15:0]     sp;
    logic            ie;
    logic [7:0]      pend;
    logic            run;
    logic            flt;
  } cpu_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  irq;
    logic [7:0]  iord;
    logic        typed;
    res_t        exp;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = '0;
  logic [15:0] in_address = '0;
  logic [7:0]  in_data = '0;
  logic [7:0]  in_irq_lines = '0;
  logic [7:0]  in_io_read_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_running;
  logic        out_fault;
  logic [15:0] out_pc;
  logic [7:0]  out_acc;
  logic [2:0]  out_flags;
  logic        out_io_write;
  logic [7:0]  out_io_port;
  logic [7:0]  out_io_data;
  logic        out_io_read;

  eight_bit_cpu_core_top dut (.*);

  always #5 clk = ~clk;

  // model state
  cpu_t       cpu;
  logic [7:0] mem_img [65536];
  bit         mem_known [65536];
  logic [7:0] trial_mem [int];
  int         unknown_q [$];
  bit         trial;
  res_t       pending_q [$];
  int         errors = 0;
  int         burst_left = 1;
  int         words_sent = 0;
  int unsigned cycles = 0;

  // ---------------------------------------------------------------- memory
  function automatic logic [7:0] rd8(input logic [15:0] a);
    if (trial && trial_mem.exists(int'(a))) return trial_mem[int'(a)];
    if (!mem_known[a]) begin
      unknown_q.push_back(int'(a));
      return 8'h00;
    end
    return mem_img[a];
  endfunction

  function automatic void wr8(input logic [15:0] a, input logic [7:0] v);
    if (trial) trial_mem[int'(a)] = v;
    else begin
      mem_img[a] = v;
      mem_known[a] = 1'b1;
    end
  endfunction

  function automatic logic [15:0] pair_rd(input logic [1:0] i);
    return {cpu.rf[{i, 1'b1}], cpu.rf[{i, 1'b0}]};
  endfunction

  function automatic void pair_wr(input logic [1:0] i, input logic [15:0] v);
    cpu.rf[{i, 1'b0}] = v[7:0];
    cpu.rf[{i, 1'b1}] = v[15:8];
  endfunction

  function automatic logic [7:0] reg_rd(input logic [2:0] i);
    return (i == REG_F) ? rd8(pair_rd(2'd3)) : cpu.rf[i];
  endfunction

  function automatic void reg_wr(input logic [2:0] i, input logic [7:0] v);
    if (i == REG_F) wr8(pair_rd(2'd3), v);
    else cpu.rf[i] = v;
  endfunction

  function automatic logic [7:0] fetch8();
    logic [7:0] v;
    v = rd8(cpu.pc);
    cpu.pc = cpu.pc + 16'd1;
    return v;
  endfunction

  function automatic logic [15:0] fetch16();
    logic [7:0] lo;
    lo = fetch8();
    return {fetch8(), lo};
  endfunction

  // low byte goes to the higher address
  function automatic void push16(input logic [15:0] v);
    cpu.sp = cpu.sp - 16'd1;
    wr8(cpu.sp, v[7:0]);
    cpu.sp = cpu.sp - 16'd1;
    wr8(cpu.sp, v[15:8]);
  endfunction

  function automatic logic [15:0] pop16();
    logic [7:0] hi;
    hi = rd8(cpu.sp);
    cpu.sp = cpu.sp + 16'd1;
    cpu.sp = cpu.sp + 16'd1;
    return {hi, rd8(cpu.sp - 16'd1)};
  endfunction

  // --------------------------------------------------------------- execute
  function automatic logic [7:0] arith(input logic [2:0] op, input logic [7:0] s,
                                       input logic [7:0] v);
    logic       c;
    logic [8:0] w;
    logic [7:0] f;
    if (op == ALU_AND) return s & v;
    if (op == ALU_OR) return s | v;
    if (op == ALU_XOR) return s ^ v;
    if (op == ALU_CP) begin
      void'(arith(ALU_SUB, s, v));
      return s;
    end
    c = op[0] & cpu.rf[REG_F][FLAG_C];
    f = '0;
    if (op[1]) begin
      f[FLAG_C] = ({1'b0, v} + {8'd0, c}) > {1'b0, s};
      w = {1'b0, s} - {1'b0, v} - {8'd0, c};
    end else begin
      w = {1'b0, s} + {1'b0, v} + {8'd0, c};
      f[FLAG_C] = w[8];
    end
    f[FLAG_Z] = (w[7:0] == 8'd0);
    f[FLAG_N] = w[7];
    cpu.rf[REG_F] = f;
    return w[7:0];
  endfunction

  function automatic logic cond_true(input logic [7:0] op);
    logic b;
    if (op[1:0] == 2'd3) return 1'b1;
    b = cpu.rf[REG_F][op[1:0]];
    return op[2] ? !b : b;
  endfunction

  function automatic logic opcode_bad(input logic [7:0] op);
    return op == 8'h06 || op == 8'h07 || (op >= 8'h0C && op <= 8'h17) ||
           op == 8'h3F || op == 8'h67 || op == 8'h6F;
  endfunction

  function automatic res_t cpu_step(input logic [1:0] kind, input logic [15:0] addr,
                                    input logic [7:0] data, input logic [7:0] irq,
                                    input logic [7:0] iord);
    res_t        r;
    logic [7:0]  op;
    logic [7:0]  v;
    logic [15:0] tgt;
    r = '0;
    if (kind == KIND_LOAD) wr8(addr, data);
    else if (kind == KIND_START) begin
      cpu.run = 1'b1;
      cpu.flt = 1'b0;
    end else if (kind == KIND_EXEC && cpu.run) begin
      // interrupt entry before the fetch
      if (cpu.ie && cpu.pend != 8'd0) begin
        push16(cpu.pc);
        cpu.ie = 1'b0;
        cpu.pc = INT_VECTOR;
      end
      op = fetch8();
      if (opcode_bad(op)) begin
        cpu.flt = 1'b1;
        cpu.run = 1'b0;
      end else begin
        if (op == OP_HALT) cpu.run = 1'b0;
        else if (op == OP_EI) cpu.ie = 1'b1;
        else if (op == OP_DI) cpu.ie = 1'b0;
        else if (op == OP_GETPEND) cpu.rf[REG_A] = cpu.pend;
        else if (op == OP_CLRPEND) cpu.pend = 8'd0;
        else if (op >= OP_LD16 && op < OP_LD8) pair_wr(op[1:0], fetch16());
        else if (op >= OP_LD8 && op < OP_ALUI) begin
          v = fetch8();
          reg_wr(op[2:0], v);
        end else if (op >= OP_ALUI && op < OP_INCDEC16) begin
          v = fetch8();
          cpu.rf[REG_A] = arith(op[2:0], cpu.rf[REG_A], v);
        end else if (op >= OP_INCDEC16 && op < OP_STACK) begin
          tgt = pair_rd(op[1:0]);
          pair_wr(op[1:0], op[2] ? tgt + 16'd1 : tgt - 16'd1);
        end else if (op >= OP_STACK && op < OP_RET) begin
          if (op[2]) pair_wr(op[1:0], pop16());
          else push16(pair_rd(op[1:0]));
        end else if (op >= OP_RET && op < OP_MOV16) begin
          if (cond_true(op)) cpu.pc = pop16();
        end else if (op >= OP_MOV16 && op < OP_IO) begin
          pair_wr(op[3:2], pair_rd(op[1:0]));
        end else if (op >= OP_IO && op < OP_JP) begin
          r.io_port = reg_rd(op[2:0]);
          if (op[3]) begin
            cpu.rf[REG_A] = iord;
            r.io_read = 1'b1;
          end else begin
            r.io_data = cpu.rf[REG_A];
            r.io_write = 1'b1;
          end
        end else if (op >= OP_JP && op < OP_INCDEC8) begin
          tgt = fetch16();
          if (cond_true(op)) begin
            if (op[3]) push16(cpu.pc);
            cpu.pc = tgt;
          end
        end else if (op >= OP_INCDEC8 && op < OP_ALUR) begin
          v = reg_rd(op[2:0]);
          reg_wr(op[2:0], arith(op[3] ? ALU_ADD : ALU_SUB, v, 8'd1));
        end else if (op >= OP_ALUR && op < OP_MOV8) begin
          v = reg_rd(op[2:0]);
          cpu.rf[REG_A] = arith(op[5:3], cpu.rf[REG_A], v);
        end else if (op >= OP_MOV8) reg_wr(op[5:3], reg_rd(op[2:0]));
        cpu.pend = cpu.pend | irq;
      end
    end
    r.running = cpu.run;
    r.fault = cpu.flt;
    r.pc = cpu.pc;
    r.acc = cpu.rf[REG_A];
    r.flags = cpu.rf[REG_F][2:0];
    return r;
  endfunction

  // ------------------------------------------------------------- sending
  task automatic send_word(input logic [1:0] kind, input logic [15:0] addr,
                           input logic [7:0] data, input logic [7:0] irq,
                           input logic [7:0] iord, input logic typed, input res_t exp);
    res_t r;
    int   gap;
    @(negedge clk);
    in_kind = kind;
    in_address = addr;
    in_data = data;
    in_irq_lines = irq;
    in_io_read_data = iord;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    r = cpu_step(kind, addr, data, irq, iord);
    pending_q.push_back(typed ? exp : r);
    words_sent++;
    // bursts with random gaps between them
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // random code byte, mostly valid opcodes
  function automatic logic [7:0] code_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while ((opcode_bad(b) || b == OP_HALT) && $urandom_range(0, 99) < 95)
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // run a step on a copy; load any byte it would read before it is known
  task automatic step_with_fill(input logic [7:0] irq, input logic [7:0] iord);
    cpu_t saved;
    do begin
      saved = cpu;
      trial = 1'b1;
      trial_mem.delete();
      unknown_q.delete();
      void'(cpu_step(KIND_EXEC, '0, '0, irq, iord));
      cpu = saved;
      trial = 1'b0;
      if (unknown_q.size() > 0)
        send_word(KIND_LOAD, 16'(unknown_q[0]), code_byte(), '0,
                  8'($urandom_range(0, 255)), 1'b0, '0);
    end while (unknown_q.size() > 0);
    send_word(KIND_EXEC, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), irq,
              iord, 1'b0, '0);
  endtask

  // ------------------------------------------------------------ checking
  task automatic check_field(input string name, input logic [15:0] e,
                             input logic [15:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual pc %h",
                 $realtime, out_pc);
        errors++;
      end else begin
        e = pending_q.pop_front();
        check_field("running", 16'(e.running), 16'(out_running));
        check_field("fault", 16'(e.fault), 16'(out_fault));
        check_field("pc", e.pc, out_pc);
        check_field("acc", 16'(e.acc), 16'(out_acc));
        check_field("flags", 16'(e.flags), 16'(out_flags));
        check_field("io_write", 16'(e.io_write), 16'(out_io_write));
        check_field("io_port", 16'(e.io_port), 16'(out_io_port));
        check_field("io_data", 16'(e.io_data), 16'(out_io_data));
        check_field("io_read", 16'(e.io_read), 16'(out_io_read));
      end
    end
  end

  // receiver stall pattern: quiet, light and heavy stretches
  always @(negedge clk) begin
    case ((cycles / 400) % 3)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_stall <= ($urandom_range(0, 2) != 0);
      end
    endcase
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // directed table: typed rows come straight from the reset state
  row_t dir_tab [24] = '{
    '{KIND_EXEC,  16'h0000, 8'h00, 8'h00, 8'h00, 1'b1, res_t'(0)},
    '{KIND_NONE,  16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, res_t'(0)},
    '{KIND_LOAD,  16'hFFFF, 8'hFF, 8'h00, 8'h00, 1'b1, res_t'(0)},
    '{KIND_LOAD,  16'h0000, 8'h19, 8'h00, 8'h00, 1'b1, res_t'(0)},
    '{KIND_LOAD,  16'h0001, 8'hFF, 8'h00, 8'h00, 1'b1, res_t'(0)},
    '{KIND_LOAD,  16'h0002, 8'h20, 8'h00, 8'h00, 1'b1, res_t'(0)},
    '{KIND_LOAD,  16'h0003, 8'h01, 8'h00, 8'h00, 1'b1, res_t'(0)},
    '{KIND_LOAD,  16'h0004, OP_BAD_A, 8'h00, 8'h00, 1'b1, res_t'(0)},
    '{KIND_LOAD,  16'h0005, OP_HALT, 8'h00, 8'h00, 1'b1, res_t'(0)},
    '{KIND_START, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b1,
      '{1'b1, 1'b0, 16'h0000, 8'h00, 3'd0, 1'b0, 8'h00, 8'h00, 1'b0}},
    '{KIND_EXEC,  16'h0000, 8'h00, 8'h00, 8'h00, 1'b1,
      '{1'b1, 1'b0, 16'h0002, 8'hFF, 3'd0, 1'b0, 8'h00, 8'h00, 1'b0}},
    '{KIND_EXEC,  16'h0000, 8'h00, 8'h00, 8'h00, 1'b1,
      '{1'b1, 1'b0, 16'h0004, 8'h00, 3'd3, 1'b0, 8'h00, 8'h00, 1'b0}},
    '{KIND_EXEC,  16'h0000, 8'h00, 8'hFF, 8'h00, 1'b1,
      '{1'b0, 1'b1, 16'h0005, 8'h00, 3'd3, 1'b0, 8'h00, 8'h00, 1'b0}},
    '{KIND_START, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b1,
      '{1'b1, 1'b0, 16'h0005, 8'h00, 3'd3, 1'b0, 8'h00, 8'h00, 1'b0}},
    '{KIND_EXEC,  16'h0000, 8'h00, 8'h00, 8'h00, 1'b1,
      '{1'b0, 1'b0, 16'h0006, 8'h00, 3'd3, 1'b0, 8'h00, 8'h00, 1'b0}},
    '{KIND_LOAD,  16'h0006, OP_EI, 8'h00, 8'h00, 1'b0, res_t'(0)},
    '{KIND_LOAD,  16'h0008, 8'h58, 8'h00, 8'h00, 1'b0, res_t'(0)},
    '{KIND_LOAD,  16'h0009, 8'h3B, 8'h00, 8'h00, 1'b0, res_t'(0)},
    '{KIND_LOAD,  16'h0007, 8'h50, 8'h00, 8'h00, 1'b0, res_t'(0)},
    '{KIND_START, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, res_t'(0)},
    '{KIND_EXEC,  16'h0000, 8'h00, 8'h01, 8'h00, 1'b0, res_t'(0)},
    '{KIND_EXEC,  16'h0000, 8'h00, 8'h00, 8'hA5, 1'b0, res_t'(0)},
    '{KIND_EXEC,  16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, res_t'(0)},
    '{KIND_EXEC,  16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, res_t'(0)}
  };

  // ------------------------------------------------------------ sequence
  initial begin
    bit         paused;
    int         sel;
    logic [7:0] irq;
    cpu = '0;
    trial = 1'b0;
    paused = 1'b0;
    foreach (mem_known[i]) mem_known[i] = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i])
      send_word(dir_tab[i].kind, dir_tab[i].addr, dir_tab[i].data, dir_tab[i].irq,
                dir_tab[i].iord, dir_tab[i].typed, dir_tab[i].exp);

    // random programs with some noise words
    while (words_sent < int'(RANDOM_WORDS)) begin
      if (!paused && words_sent >= int'(RANDOM_WORDS / 2)) begin
        paused = 1'b1;
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending_q.size() == 0);
      end
      sel = $urandom_range(0, 99);
      irq = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      if (!cpu.run && sel < 90)
        send_word(KIND_START, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, '0);
      else if (sel < 86) step_with_fill(irq, 8'($urandom_range(0, 255)));
      else if (sel < 92)
        send_word(KIND_LOAD, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, '0);
      else if (sel < 96)
        send_word(KIND_START, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, '0);
      else
        send_word(KIND_NONE, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, '0);
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_q.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
